@@ hw/rtl/unique_values_with_counts_assert.svh @@
// Assertion macros shared by the RTL of the distinct-value block.
`ifndef UNIQUE_VALUES_WITH_COUNTS_ASSERT_SVH
`define UNIQUE_VALUES_WITH_COUNTS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define UVC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define UVC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`else

`define UVC_ASSERT_IMP(label, clk, rst, a, b)
`define UVC_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

@@ hw/rtl/uvc_pkg.sv @@
package uvc_pkg;

  // Fixed field widths of the transactions.
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int OCC_W   = 6;
  localparam int TOTAL_W = 6;

  // Record kinds on the output channel.
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_INVERSE = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element_value;
    logic                      is_last;
  } in_t;

  typedef struct packed {
    logic                      record_kind;
    logic signed [VALUE_W-1:0] distinct_value;
    logic [POS_W-1:0]          first_position;
    logic [OCC_W-1:0]          occurrences;
    logic [POS_W-1:0]          inverse_position;
    logic [TOTAL_W-1:0]        distinct_total;
    logic                      overflowed;
    logic                      run_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PREP,
    ST_RANK_LOAD,
    ST_RANK_SCAN,
    ST_EMIT_ENT,
    ST_EMIT_INV
  } state_t;

  // Source of the entry table read address.
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_ROW,
    RD_ORDER
  } rd_src_t;

  typedef struct packed {
    rd_src_t rd_src;
    logic    accept;
    logic    drop;
    logic    step;
    logic    ins_new;
    logic    ins_hit;
    logic    prep;
    logic    rank_load;
    logic    rank_step;
    logic    rank_store;
    logic    emit_ent;
    logic    emit_inv;
    logic    run_clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic scan_end;
    logic match;
    logic need_sort;
    logic row_last;
    logic inv_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/uvc_ctrl.sv @@
module uvc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  uvc_pkg::sts_t sts,
  output uvc_pkg::cmd_t cmd
);
  import uvc_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.full || sts.scan_end || sts.match) begin
          state_next = sts.last ? ST_PREP : ST_IDLE;
        end
      end
      ST_PREP: begin
        state_next = sts.need_sort ? ST_RANK_LOAD : ST_EMIT_ENT;
      end
      ST_RANK_LOAD: begin
        state_next = ST_RANK_SCAN;
      end
      ST_RANK_SCAN: begin
        if (sts.scan_end) state_next = sts.row_last ? ST_EMIT_ENT : ST_RANK_LOAD;
      end
      ST_EMIT_ENT: begin
        if (sts.out_free && sts.row_last) state_next = ST_EMIT_INV;
      end
      ST_EMIT_INV: begin
        if (sts.out_free && sts.inv_done) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    cmd.rd_src = RD_SCAN;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SEARCH: begin
        if (sts.full) begin
          cmd.drop = 1'b1;
        end else if (sts.scan_end) begin
          cmd.ins_new = 1'b1;
        end else if (sts.match) begin
          cmd.ins_hit = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_RANK_LOAD: begin
        cmd.rd_src    = RD_ROW;
        cmd.rank_load = 1'b1;
      end
      ST_RANK_SCAN: begin
        if (sts.scan_end) begin
          cmd.rank_store = 1'b1;
        end else begin
          cmd.rank_step = 1'b1;
        end
      end
      ST_EMIT_ENT: begin
        cmd.rd_src   = RD_ORDER;
        cmd.emit_ent = sts.out_free;
      end
      ST_EMIT_INV: begin
        cmd.emit_inv  = sts.out_free;
        cmd.run_clear = sts.out_free && sts.inv_done;
      end
      default: begin
        cmd.rd_src = RD_SCAN;
      end
    endcase
  end

endmodule

@@ hw/rtl/uvc_datapath.sv @@
module uvc_datapath #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  uvc_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  uvc_pkg::cmd_t cmd,
  output uvc_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output uvc_pkg::out_t out_data
);
  import uvc_pkg::*;

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  // Entry table, per-element inverse indices and the sort maps.
  logic [VALUE_W-1:0] ent_val    [MAX_ELEMENTS];
  logic [IW-1:0]      ent_first  [MAX_ELEMENTS];
  logic [OCC_W-1:0]   ent_cnt    [MAX_ELEMENTS];
  logic [IW-1:0]      elem_inv   [MAX_ELEMENTS];
  logic [IW-1:0]      sort_order [MAX_ELEMENTS];
  logic [IW-1:0]      sort_rank  [MAX_ELEMENTS];

  logic [VALUE_W-1:0] cur_val;
  logic               cur_last;
  logic [VALUE_W-1:0] pivot;
  logic [CW-1:0]      elem_total;
  logic [CW-1:0]      entry_total;
  logic               overflow;
  logic               sorted_mode;
  logic               sort_on;
  logic [CW-1:0]      scan;
  logic [CW-1:0]      row;
  logic [CW-1:0]      less;

  logic [IW-1:0]      scan_i;
  logic [IW-1:0]      row_i;
  logic [IW-1:0]      less_i;
  logic [IW-1:0]      elem_i;
  logic [IW-1:0]      entry_i;
  logic [IW-1:0]      rd_idx;
  logic [VALUE_W-1:0] rd_val;
  logic [IW-1:0]      inv_pos;
  logic [CW-1:0]      row_inc;
  out_t               rec_ent;
  out_t               rec_inv;

  assign scan_i  = scan[IW-1:0];
  assign row_i   = row[IW-1:0];
  assign less_i  = less[IW-1:0];
  assign elem_i  = elem_total[IW-1:0];
  assign entry_i = entry_total[IW-1:0];
  assign row_inc = row + CW'(1);

  // Single read address into the entry table.
  always_comb begin
    case (cmd.rd_src)
      RD_SCAN:  rd_idx = scan_i;
      RD_ROW:   rd_idx = row_i;
      RD_ORDER: rd_idx = sort_on ? sort_order[row_i] : row_i;
      default:  rd_idx = scan_i;
    endcase
  end

  assign rd_val  = ent_val[rd_idx];
  assign inv_pos = sort_on ? sort_rank[elem_inv[row_i]] : elem_inv[row_i];

  // Status towards the controller.
  always_comb begin
    sts.full      = (elem_total == CW'(MAX_ELEMENTS));
    sts.last      = cur_last;
    sts.scan_end  = (scan == entry_total);
    sts.match     = (rd_val == cur_val);
    sts.need_sort = sorted_mode && (entry_total > CW'(1));
    sts.row_last  = (row_inc == entry_total);
    sts.inv_done  = (row_inc == elem_total);
    sts.out_free  = !out_valid || out_ready;
  end

  // Record builders for both kinds.
  always_comb begin
    rec_ent                  = '0;
    rec_ent.record_kind      = KIND_ENTRY;
    rec_ent.distinct_value   = rd_val;
    rec_ent.first_position   = POS_W'(ent_first[rd_idx]);
    rec_ent.occurrences      = ent_cnt[rd_idx];
    rec_ent.distinct_total   = TOTAL_W'(entry_total);
    rec_ent.overflowed       = overflow;
    rec_ent.run_last         = 1'b0;
    rec_inv                  = '0;
    rec_inv.record_kind      = KIND_INVERSE;
    rec_inv.inverse_position = POS_W'(inv_pos);
    rec_inv.distinct_total   = TOTAL_W'(entry_total);
    rec_inv.overflowed       = overflow;
    rec_inv.run_last         = sts.inv_done;
  end

  // Control registers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_total  <= '0;
      entry_total <= '0;
      overflow    <= 1'b0;
      sorted_mode <= 1'b0;
      sort_on     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) sorted_mode <= cfg_wdata;
      if (cmd.drop) overflow <= 1'b1;
      if (cmd.ins_new) entry_total <= entry_total + CW'(1);
      if (cmd.ins_new || cmd.ins_hit) elem_total <= elem_total + CW'(1);
      if (cmd.prep) sort_on <= sts.need_sort;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.emit_ent || cmd.emit_inv) out_valid <= 1'b1;
      if (cmd.run_clear) begin
        elem_total  <= '0;
        entry_total <= '0;
        overflow    <= 1'b0;
      end
    end
  end

  // Payload registers and tables.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_val  <= in_data.element_value;
      cur_last <= in_data.is_last;
      scan     <= '0;
    end
    if (cmd.step) scan <= scan + CW'(1);
    if (cmd.ins_new) begin
      ent_val[entry_i]   <= cur_val;
      ent_first[entry_i] <= elem_i;
      ent_cnt[entry_i]   <= OCC_W'(1);
      elem_inv[elem_i]   <= entry_i;
    end
    if (cmd.ins_hit) begin
      ent_cnt[scan_i]  <= ent_cnt[scan_i] + OCC_W'(1);
      elem_inv[elem_i] <= scan_i;
    end
    if (cmd.prep) row <= '0;
    if (cmd.rank_load) begin
      pivot <= rd_val;
      scan  <= '0;
      less  <= '0;
    end
    if (cmd.rank_step) begin
      scan <= scan + CW'(1);
      if ($signed(rd_val) < $signed(pivot)) less <= less + CW'(1);
    end
    if (cmd.rank_store) begin
      sort_order[less_i] <= row_i;
      sort_rank[row_i]   <= less_i;
      row                <= sts.row_last ? '0 : row_inc;
    end
    if (cmd.emit_ent) begin
      out_data <= rec_ent;
      row      <= sts.row_last ? '0 : row_inc;
    end
    if (cmd.emit_inv) begin
      out_data <= rec_inv;
      row      <= row_inc;
    end
  end

endmodule

@@ hw/rtl/unique_values_with_counts.sv @@
// Distinct values of a run of signed integers, with counts and inverse indices.
// Input channel (in_valid/in_ready/in_data): one element per transaction, the
// final element of a run flagged by is_last. Output channel (out_valid/
// out_ready/out_data): after the last element, one record per distinct entry,
// then one record per stored element; run_last marks the final record.
// cfg_we/cfg_wdata write sorted_mode; write it only while the block is idle.
// Each element is accepted, then searched for sequentially among the distinct
// entries so far, as the entry table has a single read address; in_ready stays
// low during the search. Elements past MAX_ELEMENTS are dropped and set the
// overflow flag. With sorting on and more than one entry, the entries are
// ranked before output. Records then leave at one per cycle while out_ready is
// high; a stall of the receiver holds the output register and the block waits.
// The next run's first element is taken while the final record still waits.
// Synchronous reset empties the run, clears sorted_mode and the output.
module unique_values_with_counts #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  uvc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output uvc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import uvc_pkg::*;

  `include "unique_values_with_counts_assert.svh"

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  uvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, counters and output register.
  uvc_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An accepted transaction leaves the block busy, with in_ready low, in the next cycle.
  `UVC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // A new entry is never created once the element store is full.
  `UVC_ASSERT_IMP(a_no_insert_when_full, clk, rst, cmd.ins_new, !sts.full)
  // Entry records never close an output run.
  `UVC_ASSERT_IMP(a_entry_not_last, clk, rst,
    out_valid && (out_data.record_kind == KIND_ENTRY), !out_data.run_last)

endmodule

@@ tb/sv/uvc_checker.sv @@
module uvc_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  uvc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  uvc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output int            mismatches,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import uvc_pkg::*;

  localparam int CAP = 32;

  // Shadow copy of the block's run state and its mode register.
  logic signed [31:0] tbl_value [CAP];
  logic [4:0]         tbl_first [CAP];
  logic [5:0]         tbl_count [CAP];
  logic [4:0]         elem_entry [CAP];
  int                 n_elems;
  int                 n_entries;
  logic               dropped;
  logic               sort_on;

  out_t expected_records [$];

  assign pending = expected_records.size();

  // Orders the entries by ascending signed value and remaps the inverse indices.
  function automatic void rank_entries();
    int                 order [CAP];
    int                 remap [CAP];
    logic signed [31:0] tv [CAP];
    logic [4:0]         tf [CAP];
    logic [5:0]         tc [CAP];
    int                 j;
    int                 cur;
    for (int i = 0; i < n_entries; i++) order[i] = i;
    for (int i = 1; i < n_entries; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && tbl_value[order[j-1]] > tbl_value[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int k = 0; k < n_entries; k++) begin
      remap[order[k]] = k;
      tv[k] = tbl_value[order[k]];
      tf[k] = tbl_first[order[k]];
      tc[k] = tbl_count[order[k]];
    end
    for (int k = 0; k < n_entries; k++) begin
      tbl_value[k] = tv[k];
      tbl_first[k] = tf[k];
      tbl_count[k] = tc[k];
    end
    for (int i = 0; i < n_elems; i++) elem_entry[i] = 5'(remap[elem_entry[i]]);
  endfunction

  // Takes one element and, at the end of a run, queues the records it releases.
  function automatic void absorb_element(in_t item);
    int   hit;
    int   total;
    int   n;
    out_t rec;
    if (n_elems < CAP) begin
      hit = n_entries;
      for (int i = 0; i < n_entries; i++) begin
        if (tbl_value[i] == item.element_value) begin
          hit = i;
          break;
        end
      end
      if (hit == n_entries) begin
        tbl_value[hit] = item.element_value;
        tbl_first[hit] = n_elems[4:0];
        tbl_count[hit] = 6'd1;
        n_entries++;
      end else begin
        tbl_count[hit] = tbl_count[hit] + 6'd1;
      end
      elem_entry[n_elems] = hit[4:0];
      n_elems++;
    end else begin
      dropped = 1'b1;
    end
    if (!item.is_last) return;
    if (sort_on && n_entries > 1) rank_entries();
    total = n_entries + n_elems;
    n = 0;
    for (int i = 0; i < n_entries; i++) begin
      rec = '0;
      rec.record_kind    = KIND_ENTRY;
      rec.distinct_value = tbl_value[i];
      rec.first_position = tbl_first[i];
      rec.occurrences    = tbl_count[i];
      rec.distinct_total = n_entries[5:0];
      rec.overflowed     = dropped;
      n++;
      rec.run_last       = (n == total);
      expected_records.push_back(rec);
    end
    for (int i = 0; i < n_elems; i++) begin
      rec = '0;
      rec.record_kind      = KIND_INVERSE;
      rec.inverse_position = elem_entry[i];
      rec.distinct_total   = n_entries[5:0];
      rec.overflowed       = dropped;
      n++;
      rec.run_last         = (n == total);
      expected_records.push_back(rec);
    end
    n_elems = 0;
    n_entries = 0;
    dropped = 1'b0;
  endfunction

  // Watch both channels and the register port at each rising edge.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      n_elems <= 0;
      n_entries <= 0;
      dropped <= 1'b0;
      sort_on <= 1'b0;
      mismatches <= 0;
      expected_records.delete();
    end else begin
      if (cfg_we) sort_on = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          if (mismatches < 10) $display("unexpected record %p", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_records.pop_front();
          if (out_data !== want) begin
            if (mismatches < 10) $display("record mismatch: expected %p got %p", want, out_data);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) absorb_element(in_data);
    end
  end
endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uvc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   mismatches;
  int   pending;
  bit   calm = 1'b0;
  bit   hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unique_values_with_counts dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  uvc_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  // Offers one element and waits for its transaction, idling at random first.
  // Valid is lowered only while idling or when the stimulus pauses.
  task automatic send_element(logic signed [31:0] v, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{element_value: v, is_last: last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random value drawn from a small pool so repeats are common.
  function automatic logic signed [31:0] pick_value(int pool);
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, pool)) - 3;
    endcase
  endfunction

  // Sends one run of the given length with random content.
  task automatic send_run(int len);
    int pool;
    pool = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) send_element(pick_value(pool), i == len - 1);
  endtask

  // Writes the mode register once the block has drained.
  task automatic set_mode(logic m);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int sent;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed runs: extremes, single element, overflow.
    send_element(32'sh7fffffff, 1'b1);
    send_element(32'sh80000000, 1'b0);
    send_element(32'sh7fffffff, 1'b0);
    send_element(32'sh80000000, 1'b0);
    send_element(32'sh0, 1'b1);
    set_mode(1'b1);
    send_element(32'sh5, 1'b0);
    send_element(-32'sh1, 1'b0);
    send_element(32'sh7fffffff, 1'b0);
    send_element(32'sh80000000, 1'b0);
    send_element(32'sh5, 1'b1);
    hold_off = 1'b1;
    for (int i = 0; i < 34; i++) send_element(32'(i % 3), i == 33);
    set_mode(1'b0);

    // Random runs across both modes; the last stretch runs without idling.
    sent = 0;
    while (sent < 216) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
      if (sent > 170) calm = 1'b1;
      if ($urandom_range(0, 4) == 0) set_mode(1'($urandom_range(0, 1)));
      send_run(len);
      sent += len;
    end
    set_mode(1'b0);

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
